// ===== rtl/vva_pkg.sv =====
// Shared types, opcodes, sizes and arithmetic helpers for the vector ALU.
package vva_pkg;

    // Component format and derived sizes
    localparam int CW          = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SW          = CW + 18;            // headroom for sums before saturation
    localparam int PW          = 2 * CW;             // full product / sum of squares width
    localparam int QW          = PW - FRAC_BITS;     // truncated product width
    localparam int SQRT_STEPS  = CW;                 // one root bit per stage
    localparam int QBITS       = FRAC_BITS + 1;      // quotient of |c| * 2^F / len is <= 2^F
    localparam int DW          = CW + FRAC_BITS + 1; // divider remainder width
    localparam int PREP_STAGES = 4;
    localparam int LATENCY     = PREP_STAGES + SQRT_STEPS + QBITS + 1;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [PW-1:0] TRUNC_BIAS = (PW'(1) << FRAC_BITS) - PW'(1);

    // Operation codes
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_NEG    = 4'd3;
    localparam logic [3:0] OP_SCALE  = 4'd4;
    localparam logic [3:0] OP_NORM   = 4'd5;
    localparam logic [3:0] OP_CROSS  = 4'd6;
    localparam logic [3:0] OP_LENSQ  = 4'd7;
    localparam logic [3:0] OP_LEN    = 4'd8;
    localparam logic [3:0] OP_DOT    = 4'd9;
    localparam logic [3:0] OP_DIR    = 4'd10;
    localparam logic [3:0] OP_LERP   = 4'd11;
    localparam logic [3:0] OP_DISTSQ = 4'd12;
    localparam logic [3:0] OP_ISALL  = 4'd13;

    typedef struct packed {
        logic [3:0]             req_type;
        logic signed [CW-1:0]   a_x;
        logic signed [CW-1:0]   a_y;
        logic signed [CW-1:0]   a_z;
        logic signed [CW-1:0]   b_x;
        logic signed [CW-1:0]   b_y;
        logic signed [CW-1:0]   b_z;
        logic signed [CW-1:0]   scalar_in;
    } vva_req_t;

    typedef struct packed {
        logic signed [CW-1:0]   res_x;
        logic signed [CW-1:0]   res_y;
        logic signed [CW-1:0]   res_z;
        logic signed [CW-1:0]   res_scalar;
        logic                   res_flag;
    } vva_res_t;

    // Transaction state carried down the pipeline
    typedef struct packed {
        logic                   valid;
        logic [3:0]             op;
        logic signed [CW-1:0]   r_x;
        logic signed [CW-1:0]   r_y;
        logic signed [CW-1:0]   r_z;
        logic signed [CW-1:0]   r_s;
        logic                   flag;
        logic signed [CW-1:0]   v_x;
        logic signed [CW-1:0]   v_y;
        logic signed [CW-1:0]   v_z;
    } vva_item_t;

    // Saturate a widened signed value to the component range
    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        if (v > SAT_HI)
            return CMAX;
        else if (v < SAT_LO)
            return CMIN;
        else
            return v[CW-1:0];
    endfunction

    // Saturate an unsigned value to the positive component range
    function automatic logic signed [CW-1:0] satu(input logic [PW-1:0] v);
        if (v > PW'(CMAX))
            return CMAX;
        else
            return v[CW-1:0];
    endfunction

    // Drop fraction bits of a full product, rounding toward zero
    function automatic logic signed [QW-1:0] mulq(input logic signed [PW-1:0] p);
        logic [PW-1:0] t;
        t = p + (p[PW-1] ? TRUNC_BIAS : '0);
        return t[PW-1:FRAC_BITS];
    endfunction

endpackage

// ===== rtl/vec3_vector_alu_core.sv =====
// Top level of the three-component Q16.16 vector ALU.
// One transaction enters on any cycle with start high; busy stays low, so a new
// transaction may follow every cycle. From accept to its done strobe, every
// transaction passes through four front-end stages (register, decode, multiply,
// combine), 32 square-root stages, 17 divider stages and the output register.
// Most of that path is the square root and divider pipelines, and all operations
// share them so results leave in request order. The receiver cannot stall; each
// result is on res for the one cycle that done is high.
module vec3_vector_alu_core import vva_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  vva_req_t req,
    output logic     done,
    output vva_res_t res
);

    vva_item_t             prep_item, sqrt_item, div_item;
    logic [PW-1:0]         prep_sum;
    logic [CW-1:0]         sqrt_len, div_len;
    logic [2:0][QBITS-1:0] div_quo;

    logic                  done_reg;
    vva_res_t              res_reg, res_next;
    logic signed [CW-1:0]  unit [3];

    assign busy = 1'b0;

    vva_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .req      (req),
        .item     (prep_item),
        .sum      (prep_sum)
    );

    vva_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (prep_item),
        .sum_in   (prep_sum),
        .item_out (sqrt_item),
        .len_out  (sqrt_len)
    );

    vva_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (sqrt_item),
        .len_in   (sqrt_len),
        .item_out (div_item),
        .len_out  (div_len),
        .quo_out  (div_quo)
    );

    // Apply signs to the quotients and pick the final result
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            unit[i] = CW'(div_quo[i]);
        if (div_item.v_x[CW-1]) unit[0] = -unit[0];
        if (div_item.v_y[CW-1]) unit[1] = -unit[1];
        if (div_item.v_z[CW-1]) unit[2] = -unit[2];

        res_next.res_x      = div_item.r_x;
        res_next.res_y      = div_item.r_y;
        res_next.res_z      = div_item.r_z;
        res_next.res_scalar = div_item.r_s;
        res_next.res_flag   = div_item.flag;

        case (div_item.op) inside
            OP_NORM, OP_DIR:
            begin
                if (div_len == '0)
                begin
                    res_next.res_x    = '0;
                    res_next.res_y    = '0;
                    res_next.res_z    = '0;
                    res_next.res_flag = 1'b1;
                end
                else
                begin
                    res_next.res_x = unit[0];
                    res_next.res_y = unit[1];
                    res_next.res_z = unit[2];
                end
            end
            OP_LEN:
                res_next.res_scalar = satu(PW'(div_len));
            default:
            begin
            end
        endcase
    end

    // Drive the output strobe and hold the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_item.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/vva_prep.sv =====
// Front end: request register, operand select, six multipliers, result combine.
module vva_prep import vva_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  vva_req_t  req,
    output vva_item_t item,
    output logic [PW-1:0] sum
);

    logic                 s1_valid_reg;
    vva_req_t             s1_req_reg;

    vva_item_t            s2_item_reg, s2_item_next;
    logic signed [CW-1:0] s2_ma_reg [6];
    logic signed [CW-1:0] s2_mb_reg [6];
    logic signed [CW-1:0] s2_ma_next [6];
    logic signed [CW-1:0] s2_mb_next [6];

    vva_item_t            s3_item_reg;
    logic signed [PW-1:0] s3_prod_reg [6];

    vva_item_t            s4_item_reg, s4_item_next;
    logic [PW-1:0]        s4_sum_reg, s4_sum_next;

    logic signed [CW-1:0] dab [3];
    logic signed [CW-1:0] dba [3];
    logic signed [CW-1:0] va [3];
    logic signed [CW-1:0] vb [3];
    logic signed [CW-1:0] sq [3];
    logic signed [QW-1:0] q [6];

    // Register the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= req;
    end

    // Decode: differences, simple results and multiplier operands
    always_comb
    begin
        va[0] = s1_req_reg.a_x;
        va[1] = s1_req_reg.a_y;
        va[2] = s1_req_reg.a_z;
        vb[0] = s1_req_reg.b_x;
        vb[1] = s1_req_reg.b_y;
        vb[2] = s1_req_reg.b_z;
        for (int i = 0; i < 3; i++)
        begin
            dab[i] = sat(SW'(va[i]) - SW'(vb[i]));
            dba[i] = sat(SW'(vb[i]) - SW'(va[i]));
            if (s1_req_reg.req_type == OP_DIR)
                sq[i] = dab[i];
            else if (s1_req_reg.req_type == OP_DISTSQ)
                sq[i] = dba[i];
            else
                sq[i] = va[i];
        end

        s2_item_next       = '0;
        s2_item_next.valid = s1_valid_reg;
        s2_item_next.op    = s1_req_reg.req_type;
        s2_item_next.v_x   = (s1_req_reg.req_type == OP_DIR) ? dab[0] : va[0];
        s2_item_next.v_y   = (s1_req_reg.req_type == OP_DIR) ? dab[1] : va[1];
        s2_item_next.v_z   = (s1_req_reg.req_type == OP_DIR) ? dab[2] : va[2];

        for (int i = 0; i < 3; i++)
        begin
            s2_ma_next[i]     = sq[i];
            s2_mb_next[i]     = sq[i];
            s2_ma_next[i + 3] = '0;
            s2_mb_next[i + 3] = '0;
        end

        unique case (s1_req_reg.req_type) inside
            OP_ADD:
            begin
                s2_item_next.r_x = sat(SW'(va[0]) + SW'(vb[0]));
                s2_item_next.r_y = sat(SW'(va[1]) + SW'(vb[1]));
                s2_item_next.r_z = sat(SW'(va[2]) + SW'(vb[2]));
            end
            OP_SUB:
            begin
                s2_item_next.r_x = dab[0];
                s2_item_next.r_y = dab[1];
                s2_item_next.r_z = dab[2];
            end
            OP_NEG:
            begin
                s2_item_next.r_x = sat(-SW'(va[0]));
                s2_item_next.r_y = sat(-SW'(va[1]));
                s2_item_next.r_z = sat(-SW'(va[2]));
            end
            OP_ISALL:
            begin
                s2_item_next.flag = (va[0] == s1_req_reg.scalar_in) &&
                                    (va[1] == s1_req_reg.scalar_in) &&
                                    (va[2] == s1_req_reg.scalar_in);
            end
            OP_MUL, OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s2_ma_next[i] = va[i];
                    s2_mb_next[i] = vb[i];
                end
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s2_ma_next[i] = va[i];
                    s2_mb_next[i] = s1_req_reg.scalar_in;
                end
            end
            OP_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s2_ma_next[i] = s1_req_reg.scalar_in;
                    s2_mb_next[i] = dba[i];
                end
            end
            OP_CROSS:
            begin
                s2_ma_next[0] = va[1]; s2_mb_next[0] = vb[2];
                s2_ma_next[1] = va[2]; s2_mb_next[1] = vb[1];
                s2_ma_next[2] = va[2]; s2_mb_next[2] = vb[0];
                s2_ma_next[3] = va[0]; s2_mb_next[3] = vb[2];
                s2_ma_next[4] = va[0]; s2_mb_next[4] = vb[1];
                s2_ma_next[5] = va[1]; s2_mb_next[5] = vb[0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_item_reg <= '0;
        else
            s2_item_reg <= s2_item_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
        begin
            s2_ma_reg[k] <= s2_ma_next[k];
            s2_mb_reg[k] <= s2_mb_next[k];
        end
    end

    // Multiply: six full-width products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_item_reg <= '0;
        else
            s3_item_reg <= s2_item_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
            s3_prod_reg[k] <= PW'(s2_ma_reg[k]) * PW'(s2_mb_reg[k]);
    end

    // Combine products into the result for each operation
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            q[k] = mulq(s3_prod_reg[k]);

        s4_sum_next  = $unsigned(s3_prod_reg[0]) + $unsigned(s3_prod_reg[1]) +
                       $unsigned(s3_prod_reg[2]);
        s4_item_next = s3_item_reg;

        case (s3_item_reg.op) inside
            OP_MUL, OP_SCALE:
            begin
                s4_item_next.r_x = sat(SW'(q[0]));
                s4_item_next.r_y = sat(SW'(q[1]));
                s4_item_next.r_z = sat(SW'(q[2]));
            end
            OP_CROSS:
            begin
                s4_item_next.r_x = sat(SW'(q[0]) - SW'(q[1]));
                s4_item_next.r_y = sat(SW'(q[2]) - SW'(q[3]));
                s4_item_next.r_z = sat(SW'(q[4]) - SW'(q[5]));
            end
            OP_DOT:
                s4_item_next.r_s = sat(SW'(q[0]) + SW'(q[1]) + SW'(q[2]));
            OP_LERP:
            begin
                s4_item_next.r_x = sat(SW'(s3_item_reg.v_x) + SW'(q[0]));
                s4_item_next.r_y = sat(SW'(s3_item_reg.v_y) + SW'(q[1]));
                s4_item_next.r_z = sat(SW'(s3_item_reg.v_z) + SW'(q[2]));
            end
            OP_LENSQ, OP_DISTSQ:
                s4_item_next.r_s = satu(s4_sum_next >> FRAC_BITS);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_item_reg <= '0;
        else
            s4_item_reg <= s4_item_next;
    end

    always_ff @(posedge clk)
    begin
        s4_sum_reg <= s4_sum_next;
    end

    assign item = s4_item_reg;
    assign sum  = s4_sum_reg;

endmodule

// ===== rtl/vva_sqrt.sv =====
// Pipelined integer square root of the sum of squares, one root bit per stage.
module vva_sqrt import vva_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  vva_item_t     item_in,
    input  logic [PW-1:0] sum_in,
    output vva_item_t     item_out,
    output logic [CW-1:0] len_out
);

    vva_item_t     item_reg [SQRT_STEPS];
    logic [PW-1:0] rem_reg  [SQRT_STEPS];
    logic [PW-1:0] root_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [PW-1:0] BIT = PW'(1) << (2 * (SQRT_STEPS - 1 - k));

        vva_item_t     item_cur;
        logic [PW-1:0] rem_cur, root_cur, trial, rem_next, root_next;

        if (k == 0)
        begin : g_first
            assign item_cur = item_in;
            assign rem_cur  = sum_in;
            assign root_cur = '0;
        end
        else
        begin : g_rest
            assign item_cur = item_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
        end

        // Try to subtract the next root bit
        always_comb
        begin
            trial = root_cur + BIT;
            if (rem_cur >= trial)
            begin
                rem_next  = rem_cur - trial;
                root_next = (root_cur >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_cur;
                root_next = root_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                item_reg[k] <= '0;
            else
                item_reg[k] <= item_cur;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign item_out = item_reg[SQRT_STEPS-1];
    assign len_out  = root_reg[SQRT_STEPS-1][CW-1:0];

endmodule

// ===== rtl/vva_div.sv =====
// Pipelined restoring divider: three lanes of |c| * 2^F / len, one quotient bit per stage.
module vva_div import vva_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  vva_item_t              item_in,
    input  logic [CW-1:0]          len_in,
    output vva_item_t              item_out,
    output logic [CW-1:0]          len_out,
    output logic [2:0][QBITS-1:0]  quo_out
);

    vva_item_t              item_reg [QBITS];
    logic [CW-1:0]          len_reg  [QBITS];
    logic [2:0][DW-1:0]     rem_reg  [QBITS];
    logic [2:0][QBITS-1:0]  quo_reg  [QBITS];

    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        localparam int SH = QBITS - 1 - k;

        vva_item_t              item_cur;
        logic [CW-1:0]          len_cur;
        logic [2:0][DW-1:0]     rem_cur;
        logic [2:0][QBITS-1:0]  quo_cur;
        logic [2:0][DW-1:0]     rem_next;
        logic [2:0][QBITS-1:0]  quo_next;
        logic [DW-1:0]          den;

        if (k == 0)
        begin : g_first
            logic signed [CW-1:0] comp [3];
            logic [CW-1:0]        mag  [3];

            // Load magnitudes scaled by 2^F
            always_comb
            begin
                comp[0] = item_in.v_x;
                comp[1] = item_in.v_y;
                comp[2] = item_in.v_z;
                for (int i = 0; i < 3; i++)
                begin
                    mag[i]     = comp[i][CW-1] ? CW'(-comp[i]) : CW'(comp[i]);
                    rem_cur[i] = DW'({mag[i], {FRAC_BITS{1'b0}}});
                end
            end

            assign item_cur = item_in;
            assign len_cur  = len_in;
            assign quo_cur  = '0;
        end
        else
        begin : g_rest
            assign item_cur = item_reg[k-1];
            assign len_cur  = len_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign quo_cur  = quo_reg[k-1];
        end

        // Compare and subtract the shifted divisor in each lane
        always_comb
        begin
            den = DW'(len_cur) << SH;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_cur[i] >= den)
                begin
                    rem_next[i] = rem_cur[i] - den;
                    quo_next[i] = {quo_cur[i][QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_cur[i];
                    quo_next[i] = {quo_cur[i][QBITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                item_reg[k] <= '0;
            else
                item_reg[k] <= item_cur;
        end

        always_ff @(posedge clk)
        begin
            len_reg[k] <= len_cur;
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
        end
    end

    assign item_out = item_reg[QBITS-1];
    assign len_out  = len_reg[QBITS-1];
    assign quo_out  = quo_reg[QBITS-1];

endmodule

// ===== rtl/vva_chk.sv =====
// Port-level checker for the vector ALU, bound to the top level.
module vva_chk import vva_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input vva_res_t res
);

    // Never refuse a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    // Every accepted transaction yields a result after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after accepted transaction");

    // No result without a transaction accepted the latency earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    // A flagged result carries a zero vector and a zero scalar
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.res_flag) |-> (res.res_x == '0 && res.res_y == '0 &&
                                    res.res_z == '0 && res.res_scalar == '0))
        else $error("flagged result with nonzero data");

endmodule

bind vec3_vector_alu_core vva_chk u_vva_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);

// ===== tb/tb_vec3_vector_alu_core.sv =====
// Testbench for the vector ALU: directed and random requests checked against a predictor.
module tb_vec3_vector_alu_core;
    import vva_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    vva_req_t req;
    logic     done;
    vva_res_t res;

    vva_res_t expected_q[$];
    int       mismatches;
    int       sender_gap_pct;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;

    vec3_vector_alu_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    // Toggle the clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Clamp to the Q16.16 range
    function automatic longint clamp_q(input longint v);
        if (v > QMAX)
            return QMAX;
        if (v < QMIN)
            return QMIN;
        return v;
    endfunction

    // Fixed-point product, truncated toward zero
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return longint'(64'(p) >> FRAC_BITS);
        return -longint'(64'(-p) >> FRAC_BITS);
    endfunction

    function automatic logic [63:0] sum_squares(input longint x, input longint y,
                                                input longint z);
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] mz;
        mx = x < 0 ? -x : x;
        my = y < 0 ? -y : y;
        mz = z < 0 ? -z : z;
        return mx * mx + my * my + mz * mz;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_u(input logic [63:0] v);
        if (v > 64'(QMAX))
            return QMAX;
        return longint'(v);
    endfunction

    // Unit vector of v; zero length gives zero vector and flag
    function automatic void unit_vector(input longint v[3], input bit pass_unit,
                                        output longint r[3], output logic flag);
        logic [63:0] len;
        logic [63:0] m;
        logic [63:0] q;
        len = int_sqrt(sum_squares(v[0], v[1], v[2]));
        flag = 1'b0;
        for (int i = 0; i < 3; i++)
            r[i] = 0;
        if (len == 0)
        begin
            flag = 1'b1;
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (pass_unit && len == 64'(ONE_Q))
                r[i] = v[i];
            else
            begin
                m = v[i] < 0 ? -v[i] : v[i];
                q = (m << FRAC_BITS) / len;
                r[i] = v[i] < 0 ? clamp_q(-clamp_u(q)) : clamp_u(q);
            end
        end
    endfunction

    // Compute the expected result of one request
    function automatic vva_res_t vector_result(input vva_req_t rq);
        longint   a[3];
        longint   b[3];
        longint   d[3];
        longint   r[3];
        longint   s;
        longint   sc;
        logic     flag;
        vva_res_t o;
        a[0] = rq.a_x; a[1] = rq.a_y; a[2] = rq.a_z;
        b[0] = rq.b_x; b[1] = rq.b_y; b[2] = rq.b_z;
        s = rq.scalar_in;
        sc = 0;
        flag = 1'b0;
        for (int i = 0; i < 3; i++)
            r[i] = 0;
        case (rq.req_type)
            OP_ADD:    for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] + b[i]);
            OP_SUB:    for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] - b[i]);
            OP_MUL:    for (int i = 0; i < 3; i++) r[i] = clamp_q(fx_mul(a[i], b[i]));
            OP_NEG:    for (int i = 0; i < 3; i++) r[i] = clamp_q(-a[i]);
            OP_SCALE:  for (int i = 0; i < 3; i++) r[i] = clamp_q(fx_mul(a[i], s));
            OP_NORM:   unit_vector(a, 1'b1, r, flag);
            OP_CROSS:
            begin
                r[0] = clamp_q(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
                r[1] = clamp_q(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
                r[2] = clamp_q(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
            end
            OP_LENSQ:  sc = clamp_u(sum_squares(a[0], a[1], a[2]) >> FRAC_BITS);
            OP_LEN:    sc = clamp_u(int_sqrt(sum_squares(a[0], a[1], a[2])));
            OP_DOT:
                sc = clamp_q(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]));
            OP_DIR:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = clamp_q(a[i] - b[i]);
                unit_vector(d, 1'b0, r, flag);
            end
            OP_LERP:
                for (int i = 0; i < 3; i++)
                    r[i] = clamp_q(a[i] + fx_mul(s, clamp_q(b[i] - a[i])));
            OP_DISTSQ:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = clamp_q(b[i] - a[i]);
                sc = clamp_u(sum_squares(d[0], d[1], d[2]) >> FRAC_BITS);
            end
            OP_ISALL:  flag = (a[0] == s && a[1] == s && a[2] == s);
            default: ;
        endcase
        o.res_x = r[0][31:0];
        o.res_y = r[1][31:0];
        o.res_z = r[2][31:0];
        o.res_scalar = sc[31:0];
        o.res_flag = flag;
        return o;
    endfunction

    // Send one transaction, with optional idle cycles ahead of it
    task automatic send_request(input vva_req_t rq);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(vector_result(rq));
        @(negedge clk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res);
            end
            else
            begin
                vva_res_t e;
                e = expected_q.pop_front();
                if (res !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%h y=%h z=%h s=%h f=%b",
                                  " got x=%h y=%h z=%h s=%h f=%b"},
                                 e.res_x, e.res_y, e.res_z, e.res_scalar, e.res_flag,
                                 res.res_x, res.res_y, res.res_z, res.res_scalar,
                                 res.res_flag);
                end
            end
        end
    end

    // Pick a component value, biased toward edges and small magnitudes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(3) << 16;
            3: return 32'($signed($urandom_range(4000)) - 2000);
            4: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
            default: return $urandom;
        endcase
    endfunction

    function automatic vva_req_t random_request();
        vva_req_t rq;
        logic [31:0] v;
        rq.req_type  = 4'($urandom_range(15));
        rq.a_x = pick_value(); rq.a_y = pick_value(); rq.a_z = pick_value();
        rq.b_x = pick_value(); rq.b_y = pick_value(); rq.b_z = pick_value();
        rq.scalar_in = pick_value();
        // Make the all-equal test and zero-length cases hit often
        if ($urandom_range(5) == 0)
        begin
            v = pick_value();
            rq.a_x = v; rq.a_y = v; rq.a_z = v;
            rq.scalar_in = $urandom_range(3) == 0 ? $urandom : v;
            if ($urandom_range(1) == 0)
            begin
                rq.b_x = v; rq.b_y = v; rq.b_z = v;
            end
        end
        return rq;
    endfunction

    function automatic vva_req_t make_req(input logic [3:0] op, input logic [31:0] ax,
                                          input logic [31:0] ay, input logic [31:0] az,
                                          input logic [31:0] bx, input logic [31:0] s);
        vva_req_t rq;
        rq.req_type = op;
        rq.a_x = ax; rq.a_y = ay; rq.a_z = az;
        rq.b_x = bx; rq.b_y = -bx; rq.b_z = bx ^ 32'h5a5a_5a5a;
        rq.scalar_in = s;
        return rq;
    endfunction

    // Directed: every operation, extremes, zero length, unit length, all-equal
    task automatic test_directed();
        send_request(make_req(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff, 0));
        send_request(make_req(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0));
        send_request(make_req(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                              32'h8000_0000, 0));
        send_request(make_req(OP_NEG, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
        send_request(make_req(OP_SCALE, 32'h0001_8000, 32'hffff_0001, 3, 0, 32'h8000_0000));
        send_request(make_req(OP_NORM, 0, 0, 0, 0, 0));
        send_request(make_req(OP_NORM, 32'h0001_0000, 0, 0, 0, 0));
        send_request(make_req(OP_NORM, 0, 32'hffff_0000, 0, 0, 0));
        send_request(make_req(OP_NORM, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
        send_request(make_req(OP_NORM, 1, 0, 0, 0, 0));
        send_request(make_req(OP_CROSS, 32'h7fff_ffff, 32'h8000_0000, 32'h0002_0000,
                              32'h8000_0000, 0));
        send_request(make_req(OP_LENSQ, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send_request(make_req(OP_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
        send_request(make_req(OP_DOT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              32'h8000_0000, 0));
        send_request(make_req(OP_DIR, 32'h7fff_ffff, 32'h8000_0000, 5, 32'h8000_0000, 0));
        send_request(make_req(OP_DIR, 32'h5a5a_5a5a, 32'ha5a5_a5a6, 32'h0, 32'h5a5a_5a5a, 0));
        send_request(make_req(OP_LERP, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff,
                              32'h7fff_ffff));
        send_request(make_req(OP_DISTSQ, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0));
        send_request(make_req(OP_ISALL, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 0,
                              32'h1234_5678));
        send_request(make_req(OP_ISALL, 32'h1234_5678, 32'h1234_5678, 32'h1234_5679, 0,
                              32'h1234_5678));
        send_request(make_req(4'd14, 32'hffff_ffff, 1, 2, 3, 4));
        send_request(make_req(4'd15, 32'hffff_ffff, 1, 2, 3, 4));
    endtask

    task automatic test_random(input int count, input int gap_pct);
        sender_gap_pct = gap_pct;
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    // Hold off until the pipeline has drained
    task automatic test_drain();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        mismatches = 0;
        sender_gap_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(430, 7);
        test_drain();
        test_random(430, 80);
        test_random(440, 0);
        start <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vva_pkg.sv
rtl/vva_prep.sv
rtl/vva_sqrt.sv
rtl/vva_div.sv
rtl/vec3_vector_alu_core.sv
rtl/vva_chk.sv
tb/tb_vec3_vector_alu_core.sv
